FILE: rtl/core/assert_macros.svh
// Assertion helpers for the directory scan RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define E2DS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2ds same-cycle check failed");

// Next-cycle implication, held off while in reset.
`define E2DS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2ds next-cycle check failed");

`endif

FILE: rtl/core/e2ds_pkg.sv
// Shared types and constants for the ext2 directory entry scan.
// No dependencies; used by the input and config interfaces and every module.
`default_nettype none

package e2ds_pkg;

  localparam int NAME_MAX_BYTES  = 255;
  localparam int BLOCK_MAX_BYTES = 4096;
  localparam int HDR_BYTES       = 8;
  localparam int NAME_LEN_MAX    = 255;

  typedef logic [7:0]  name_addr_t;
  typedef logic [7:0]  name_len_t;
  typedef logic [12:0] blk_off_t;
  typedef logic [15:0] rec_off_t;
  typedef logic [1:0]  cfg_index_t;

  localparam cfg_index_t REG_FILE_TYPE_NAMES = 2'd0;
  localparam cfg_index_t REG_INODE_LIMIT     = 2'd1;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       first;
    blk_off_t   block_limit;
    logic       final_block;
  } item_t;

  typedef struct packed {
    logic        file_type_names;
    logic [31:0] inode_limit;
  } cfg_t;

  typedef struct packed {
    logic       en;
    name_addr_t addr;
    logic [7:0] data;
  } name_wr_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] inode;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/e2ds_ifs.sv
// Handshake channel interfaces: input items, result items, register writes.
// Depends on e2ds_pkg.
`default_nettype none

interface e2ds_in_if;
  import e2ds_pkg::*;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  logic       first;
  blk_off_t   block_limit;
  logic       final_block;
  modport source (output valid, kind, data, first, block_limit, final_block, input ready);
  modport sink   (input valid, kind, data, first, block_limit, final_block, output ready);
endinterface

interface e2ds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] hit_inode;
  modport source (output valid, status, hit_inode, input ready);
  modport sink   (input valid, status, hit_inode, output ready);
endinterface

interface e2ds_cfg_if;
  import e2ds_pkg::*;
  logic        valid;
  logic        ready;
  cfg_index_t  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/e2ds_name_store.sv
// Wanted-name byte store: one write port, one registered read port.
// Write-to-read bypass on an address match. Depends on e2ds_pkg.
`default_nettype none

module e2ds_name_store (
  input  logic                 clk,
  input  e2ds_pkg::name_wr_t   wr,
  input  e2ds_pkg::name_addr_t raddr,
  output logic [7:0]           rdata
);
  import e2ds_pkg::*;

  logic [7:0] mem [0:NAME_MAX_BYTES-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (wr.en && (wr.addr == raddr)) begin
      rdata <= wr.data;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/e2ds_parser.sv
// Record parser and name compare: scan state registers plus the per-byte step.
// Prefetches the next name byte from the store. Depends on e2ds_pkg.
`default_nettype none

module e2ds_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  e2ds_pkg::item_t      item,
  input  e2ds_pkg::cfg_t       cfg,
  input  logic [7:0]           name_rdata,
  output e2ds_pkg::name_wr_t   name_wr,
  output e2ds_pkg::name_addr_t name_raddr,
  output e2ds_pkg::result_t    res,
  output logic                 idle
);
  import e2ds_pkg::*;

  name_len_t   want_len, want_len_next;
  blk_off_t    block_offset, block_offset_next;
  rec_off_t    record_offset, record_offset_next;
  rec_off_t    record_bytes, record_bytes_next;
  rec_off_t    entry_name_length, entry_name_length_next;
  logic [31:0] entry_number, entry_number_next;
  logic        names_agree, names_agree_next;
  logic        search_over, search_over_next;
  rec_off_t    rd_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      want_len          <= '0;
      block_offset      <= '0;
      record_offset     <= '0;
      record_bytes      <= '0;
      entry_name_length <= '0;
      entry_number      <= '0;
      names_agree       <= 1'b1;
      search_over       <= 1'b1;
    end else begin
      want_len          <= want_len_next;
      block_offset      <= block_offset_next;
      record_offset     <= record_offset_next;
      record_bytes      <= record_bytes_next;
      entry_name_length <= entry_name_length_next;
      entry_number      <= entry_number_next;
      names_agree       <= names_agree_next;
      search_over       <= search_over_next;
    end
  end

  always_comb begin
    blk_off_t    lim;
    blk_off_t    o;
    blk_off_t    start;
    rec_off_t    r;
    rec_off_t    idx;
    rec_off_t    rb_b;
    rec_off_t    enl_b;
    logic [31:0] en_b;
    logic        bad_hdr;
    logic [16:0] r_inc;

    want_len_next          = want_len;
    block_offset_next      = block_offset;
    record_offset_next     = record_offset;
    record_bytes_next      = record_bytes;
    entry_name_length_next = entry_name_length;
    entry_number_next      = entry_number;
    names_agree_next       = names_agree;
    search_over_next       = search_over;
    name_wr = '0;
    res     = '0;
    lim     = '0;
    o       = '0;
    start   = '0;
    r       = '0;
    idx     = '0;
    rb_b    = '0;
    enl_b   = '0;
    en_b    = '0;
    bad_hdr = 1'b0;
    r_inc   = '0;

    if (step && !item.kind) begin
      if (item.first) begin
        search_over_next   = 1'b0;
        block_offset_next  = '0;
        record_offset_next = '0;
        names_agree_next   = 1'b1;
        want_len_next      = '0;
      end
      // bytes past the store depth are dropped
      if (want_len_next != name_len_t'(NAME_MAX_BYTES)) begin
        name_wr.en    = 1'b1;
        name_wr.addr  = want_len_next;
        name_wr.data  = item.data;
        want_len_next = want_len_next + 8'd1;
      end
    end else if (step && !search_over) begin
      lim = (item.block_limit > blk_off_t'(BLOCK_MAX_BYTES)) ?
            blk_off_t'(BLOCK_MAX_BYTES) : item.block_limit;
      o = item.first ? '0 : block_offset;
      r = item.first ? '0 : record_offset;
      if (item.first) begin
        block_offset_next  = '0;
        record_offset_next = '0;
      end
      if (o < lim) begin
        block_offset_next = o + 13'd1;
        en_b  = (r == '0) ? '0 : entry_number;
        rb_b  = (r == '0) ? '0 : record_bytes;
        enl_b = (r == '0) ? '0 : entry_name_length;
        if ((r == '0) && ((lim - o) < blk_off_t'(HDR_BYTES))) begin
          // not even a header fits in what is left of the block
          search_over_next = 1'b1;
          res.valid        = 1'b1;
          res.status       = ST_MALFORMED;
        end else begin
          start = o - 13'd7;
          idx   = r - rec_off_t'(HDR_BYTES);
          if (r < 16'd4) begin
            en_b = en_b | ({24'h000000, item.data} << {r[1:0], 3'b000});
          end else if (r == 16'd4) begin
            rb_b = {8'h00, item.data};
          end else if (r == 16'd5) begin
            rb_b = rb_b | {item.data, 8'h00};
          end else if (r == 16'd6) begin
            enl_b = {8'h00, item.data};
          end else if (r == 16'd7) begin
            if (!cfg.file_type_names) begin
              enl_b = enl_b | {item.data, 8'h00};
            end
            bad_hdr = (rb_b < rec_off_t'(HDR_BYTES)) || (rb_b[1:0] != 2'b00) ||
                      (rb_b > {3'b000, lim - start}) ||
                      (enl_b > rec_off_t'(NAME_LEN_MAX)) ||
                      (enl_b > rb_b - rec_off_t'(HDR_BYTES)) ||
                      ((en_b != '0) && (en_b > cfg.inode_limit));
            names_agree_next = (enl_b == {8'h00, want_len});
          end else if ((idx < enl_b) && names_agree) begin
            if ((idx >= rec_off_t'(NAME_MAX_BYTES)) || (idx >= {8'h00, want_len}) ||
                (name_rdata != item.data)) begin
              names_agree_next = 1'b0;
            end
          end
          entry_number_next      = en_b;
          record_bytes_next      = rb_b;
          entry_name_length_next = enl_b;
          r_inc = {1'b0, r} + 17'd1;
          if (bad_hdr) begin
            search_over_next = 1'b1;
            res.valid        = 1'b1;
            res.status       = ST_MALFORMED;
          end else if ((r >= 16'd7) && ((r - 16'd7) == enl_b) && (en_b != '0) &&
                       names_agree_next) begin
            search_over_next = 1'b1;
            res.valid        = 1'b1;
            res.status       = ST_FOUND;
            res.inode        = en_b;
          end else begin
            record_offset_next = ((r >= 16'd7) && (r_inc >= {1'b0, rb_b})) ?
                                 '0 : r_inc[15:0];
            if (((o + 13'd1) == lim) && item.final_block) begin
              search_over_next = 1'b1;
              res.valid        = 1'b1;
              res.status       = ST_NOT_FOUND;
            end
          end
        end
      end
    end
  end

  // next byte compares against name[record_offset - 8]; read it ahead from record_offset_next
  assign rd_off     = record_offset_next - rec_off_t'(HDR_BYTES);
  assign name_raddr = rd_off[7:0];
  assign idle       = search_over;

endmodule

`default_nettype wire

FILE: rtl/core/ext2_directory_entry_scan_top.sv
// An accepted item is registered in s1 and processed by the parse step; its result is then registered.
// Throughput: one item per cycle while the result output is not held off, set by the single parse
// step and the name store read, which is fetched ahead from the next record offset.
// Reset (rst, synchronous, active high): scan idle until a wanted name arrives, registers
// at their reset values, pipeline empty. The name store is not cleared.
// Depends on e2ds_pkg, e2ds_ifs, e2ds_name_store, e2ds_parser, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ext2_directory_entry_scan_top (
  input  logic         clk,
  input  logic         rst,
  e2ds_in_if.sink      item_in,
  e2ds_out_if.source   result_out,
  e2ds_cfg_if.sink     cfg
);
  import e2ds_pkg::*;

  logic        s1_valid;
  item_t       s1_item;
  logic        advance;
  logic        step;
  cfg_t        cfg_regs;
  name_wr_t    name_wr;
  name_addr_t  name_raddr;
  logic [7:0]  name_rdata;
  result_t     res;
  logic        idle;
  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_hit_inode;

  assign advance       = !out_valid || result_out.ready;
  assign step          = s1_valid && advance;
  assign item_in.ready = !s1_valid || advance;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.file_type_names <= 1'b1;
      cfg_regs.inode_limit     <= '1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FILE_TYPE_NAMES: cfg_regs.file_type_names <= cfg.data[0];
        REG_INODE_LIMIT:     cfg_regs.inode_limit     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      s1_item <= '{kind: item_in.kind, data: item_in.data, first: item_in.first,
                   block_limit: item_in.block_limit, final_block: item_in.final_block};
    end
  end

  e2ds_name_store u_name_store (
    .clk   (clk),
    .wr    (name_wr),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  e2ds_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (s1_item),
    .cfg        (cfg_regs),
    .name_rdata (name_rdata),
    .name_wr    (name_wr),
    .name_raddr (name_raddr),
    .res        (res),
    .idle       (idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_status    <= res.status;
      out_hit_inode <= res.inode;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.status    = out_status;
  assign result_out.hit_inode = out_hit_inode;

  `E2DS_ASSERT_NXT(a_result_ends_scan, step && res.valid, idle)
  `E2DS_ASSERT_IMP(a_idle_no_result, step && idle && s1_item.kind, !res.valid)
  `E2DS_ASSERT_IMP(a_inode_zero_unless_found, out_valid && (out_status != ST_FOUND),
                   out_hit_inode == '0)
  `E2DS_ASSERT_IMP(a_hit_inode_nonzero, out_valid && (out_status == ST_FOUND),
                   out_hit_inode != '0)

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for ext2_directory_entry_scan_top: a lookup tracker predicts each
// result from the accepted bytes; the tasks below drive names and directory blocks.
// Depends on e2ds_pkg, the e2ds channel interfaces and the RTL under rtl/core.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import e2ds_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES     = 200;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int MAX_PRINTS      = 40;

  typedef logic [7:0] bytes_t[$];

  typedef struct {
    status_t     status;
    logic [31:0] inode;
  } outcome_t;

  // Tracks the lookup state byte by byte and holds the outcomes still owed by the block.
  class lookup_tracker;
    logic        ftn;
    logic [31:0] inode_cap;
    logic [7:0]  wanted [NAME_MAX_BYTES];
    int unsigned wanted_len;
    int unsigned blk_pos;
    int unsigned rec_pos;
    int unsigned rec_len;
    int unsigned ent_name_len;
    int unsigned ent_inode;
    bit          agree;
    bit          idle;
    outcome_t    due[$];
    int          errors;

    function new();
      ftn          = 1'b1;
      inode_cap    = '1;
      wanted_len   = 0;
      blk_pos      = 0;
      rec_pos      = 0;
      rec_len      = 0;
      ent_name_len = 0;
      ent_inode    = 0;
      agree        = 1'b1;
      idle         = 1'b1;
      errors       = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] value);
      if (idx == REG_FILE_TYPE_NAMES) ftn = value[0];
      else if (idx == REG_INODE_LIMIT) inode_cap = value;
    endfunction

    function void conclude(status_t st, logic [31:0] ino);
      outcome_t o;
      o.status = st;
      o.inode  = ino;
      due.push_back(o);
      idle = 1'b1;
    endfunction

    function void take_byte(item_t it);
      int unsigned lim, o, r, d, start;
      d   = it.data;
      lim = it.block_limit;
      if (it.kind == 1'b0) begin
        if (it.first) begin
          wanted_len = 0;
          idle       = 1'b0;
          blk_pos    = 0;
          rec_pos    = 0;
          agree      = 1'b1;
        end
        // bytes past the name store are dropped
        if (wanted_len < NAME_MAX_BYTES) begin
          wanted[wanted_len] = it.data;
          wanted_len++;
        end
        return;
      end
      if (idle) return;
      if (lim > BLOCK_MAX_BYTES) lim = BLOCK_MAX_BYTES;
      if (it.first) begin
        blk_pos = 0;
        rec_pos = 0;
      end
      o = blk_pos;
      if (o >= lim) return;
      r = rec_pos;
      blk_pos = o + 1;
      if (r == 0) begin
        if (lim - o < HDR_BYTES) begin
          conclude(ST_MALFORMED, '0);
          return;
        end
        ent_inode    = 0;
        rec_len      = 0;
        ent_name_len = 0;
      end
      if (r < 4) begin
        ent_inode |= d << (8 * r);
      end else if (r == 4) begin
        rec_len = d;
      end else if (r == 5) begin
        rec_len |= d << 8;
      end else if (r == 6) begin
        ent_name_len = d;
      end else if (r == 7) begin
        start = o - 7;
        if (!ftn) ent_name_len |= d << 8;
        if (rec_len < HDR_BYTES || (rec_len % 4) != 0 || rec_len > lim - start ||
            ent_name_len > NAME_LEN_MAX || ent_name_len > rec_len - HDR_BYTES ||
            (ent_inode != 0 && ent_inode > inode_cap)) begin
          conclude(ST_MALFORMED, '0);
          return;
        end
        agree = (ent_name_len == wanted_len);
      end else if (r - 8 < ent_name_len && agree) begin
        if (r - 8 >= NAME_MAX_BYTES || r - 8 >= wanted_len || wanted[r - 8] != it.data)
          agree = 1'b0;
      end
      // match is decided on the last name byte, or on byte 7 for an empty name
      if (r >= 7 && r - 7 == ent_name_len && ent_inode != 0 && agree) begin
        conclude(ST_FOUND, ent_inode);
        return;
      end
      if (r >= 7 && r + 1 >= rec_len) rec_pos = 0;
      else rec_pos = (r + 1) & 32'hFFFF;
      if (o + 1 == lim && it.final_block) conclude(ST_NOT_FOUND, '0);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    task match_outcome(logic [1:0] st, logic [31:0] ino);
      outcome_t exp;
      if (due.size() == 0) begin
        report($sformatf("result with nothing due: status %0d inode %08h", st, ino));
        return;
      end
      exp = due.pop_front();
      if (st !== exp.status)
        report($sformatf("status %0d, predicted %0d", st, exp.status));
      if (ino !== exp.inode)
        report($sformatf("hit_inode %08h, predicted %08h", ino, exp.inode));
    endtask
  endclass

  logic clk;
  logic rst;

  e2ds_in_if  item_ch ();
  e2ds_out_if res_ch ();
  e2ds_cfg_if cfg_ch ();

  ext2_directory_entry_scan_top dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (res_ch),
    .cfg        (cfg_ch)
  );

  lookup_tracker tracker = new();

  int          items_sent   = 0;
  int          results_seen = 0;
  int          stall_cycles = 0;
  bit          tx_steady    = 1'b0;
  bit          hold_req     = 1'b0;
  logic        cur_ftn      = 1'b1;
  logic [31:0] cur_limit    = '1;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.kind        <= 1'b0;
    item_ch.data        <= '0;
    item_ch.first       <= 1'b0;
    item_ch.block_limit <= '0;
    item_ch.final_block <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_FILE_TYPE_NAMES;
    cfg_ch.data         <= '0;
  end

  // Monitor: results are checked before the byte taken at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        tracker.match_outcome(res_ch.status, res_ch.hit_inode);
      end
      if (item_ch.valid && item_ch.ready)
        tracker.take_byte({item_ch.kind, item_ch.data, item_ch.first,
                           item_ch.block_limit, item_ch.final_block});
      if (cfg_ch.valid && cfg_ch.ready)
        tracker.set_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result receiver: random stalls, steady stretches, and one long hold on request.
  initial begin
    int gap;
    bit got;
    bit rx_steady;
    rx_steady = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 23) == 0) rx_steady = ~rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do begin
        @(posedge clk);
        got = res_ch.valid;
      end while (!got && !hold_req);
    end
  end

  task automatic send_item(logic kind, logic [7:0] d, logic first, logic [12:0] lim,
                           logic fin);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= kind;
    item_ch.data        <= d;
    item_ch.first       <= first;
    item_ch.block_limit <= lim;
    item_ch.final_block <= fin;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic send_dir(bytes_t blk, int count, logic [12:0] lim, logic fin);
    for (int i = 0; i < count; i++) send_item(1'b1, blk[i], i == 0, lim, fin);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)),
                1'($urandom_range(0, 1)));
  endtask

  // Both registers go in one burst with valid held high between them.
  task automatic write_regs(logic ftn, logic [31:0] lim);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_FILE_TYPE_NAMES;
    cfg_ch.data  <= {31'b0, ftn};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_INODE_LIMIT;
    cfg_ch.data  <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_ftn   = ftn;
    cur_limit = lim;
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_inode();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = (cur_limit != '1) ? $urandom_range(cur_limit + 1, 32'hFFFF_FFFF) : $urandom;
      default: begin
        if (cur_limit == '1) begin
          v = $urandom;
          if (v == 0) v = 1;
        end else begin
          v = $urandom_range(1, cur_limit);
        end
      end
    endcase
    return v;
  endfunction

  // Appends one directory record: header, name, padding out to the record length.
  task automatic add_record(inout bytes_t blk, input logic [31:0] ino, input bytes_t nm,
                            input int pad);
    int rl, n, base;
    base = blk.size();
    n    = nm.size();
    rl   = ((HDR_BYTES + n + 3) / 4) * 4 + 4 * pad;
    for (int i = 0; i < 4; i++) blk.push_back(ino[8*i +: 8]);
    blk.push_back(rl[7:0]);
    blk.push_back(rl[15:8]);
    blk.push_back(n[7:0]);
    if (cur_ftn)
      blk.push_back(8'($urandom_range(0, 255)));
    else if ($urandom_range(0, 19) == 0)
      blk.push_back(8'($urandom_range(1, 255)));   // name length above 255
    else
      blk.push_back(8'(n >> 8));
    foreach (nm[i]) blk.push_back(nm[i]);
    while (blk.size() < base + rl) blk.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic run_directed();
    bytes_t blk, nm;
    send_item(1'b1, 8'hFF, 1'b1, 13'h1FFF, 1'b1);       // idle: ignored
    send_item(1'b0, 8'h5A, 1'b0, 13'd0, 1'b0);          // appended, search stays idle
    send_item(1'b1, 8'h00, 1'b1, 13'd8, 1'b1);          // still ignored
    send_item(1'b0, 8'h00, 1'b1, 13'd0, 1'b0);
    send_item(1'b1, 8'h00, 1'b1, 13'd0, 1'b1);          // zero limit
    send_item(1'b1, 8'hA5, 1'b1, 13'd5, 1'b0);          // too short for a header
    send_item(1'b0, 8'hFF, 1'b1, 13'h1FFF, 1'b1);
    nm = {8'hFF};
    add_record(blk, 32'hFFFF_FFFF, nm, 0);
    send_dir(blk, 9, 13'd4096, 1'b1);
    send_item(1'b0, 8'h80, 1'b1, 13'd0, 1'b0);
    blk = {};
    nm  = {};
    add_record(blk, 32'h0, nm, 0);
    send_dir(blk, 8, 13'd8, 1'b1);                       // empty entry, end of directory
  endtask

  task automatic run_lookup(bit force_long);
    bytes_t name, eff, blk, nm;
    int nlen, nblk, hit_blk, hit_rec, nrec, lim, cnt, pad, j;
    bit hit;
    logic [7:0] d;
    tx_steady = ($urandom_range(0, 4) == 0);
    if (force_long) nlen = $urandom_range(256, 260);
    else if ($urandom_range(0, 29) == 0) nlen = $urandom_range(250, 259);
    else nlen = $urandom_range(1, 6);
    for (int i = 0; i < nlen; i++) name.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < nlen; i++) begin
      send_item(1'b0, name[i], i == 0, 13'($urandom_range(0, 8191)),
                1'($urandom_range(0, 1)));
      if (i < NAME_MAX_BYTES) eff.push_back(name[i]);
    end
    nblk    = $urandom_range(1, 3);
    hit     = ($urandom_range(0, 2) != 0);
    hit_blk = $urandom_range(0, nblk - 1);
    hit_rec = $urandom_range(0, 2);
    for (int b = 0; b < nblk; b++) begin
      if (b > 0 && $urandom_range(0, 9) == 0) begin
        d = 8'($urandom_range(0, 255));
        send_item(1'b0, d, 1'b0, 13'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
        if (eff.size() < NAME_MAX_BYTES) eff.push_back(d);
      end
      blk  = {};
      nrec = $urandom_range(1, 3);
      for (int k = 0; k < nrec; k++) begin
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        if (hit && b == hit_blk && k == hit_rec % nrec) begin
          add_record(blk, pick_inode(), eff, pad);
        end else begin
          nm = {};
          case ($urandom_range(0, 3))
            0: begin
              nm = eff;
              j  = $urandom_range(0, nm.size() - 1);
              nm[j] ^= 8'($urandom_range(1, 255));
            end
            1: begin
              nm = eff;
              void'(nm.pop_back());
            end
            default: repeat ($urandom_range(0, 6)) nm.push_back(8'($urandom_range(0, 255)));
          endcase
          add_record(blk, pick_inode(), nm, pad);
        end
      end
      lim = blk.size();
      cnt = blk.size();
      case ($urandom_range(0, 11))
        0: blk[$urandom_range(0, cnt - 1)] ^= 8'($urandom_range(1, 255));
        1: lim = $urandom_range(0, cnt);                // trailing bytes fall past the limit
        2: lim = $urandom_range(0, 1) ? BLOCK_MAX_BYTES
                                      : $urandom_range(BLOCK_MAX_BYTES + 1, 8191);
        3: cnt = $urandom_range(1, cnt);                // next block start drops the rest
        default: ;
      endcase
      send_dir(blk, cnt, 13'(lim), b == nblk - 1);
    end
  endtask

  // Back-to-back short lookups, each ending malformed at once, while results are held off.
  task automatic pressure_burst();
    hold_req  = 1'b1;
    tx_steady = 1'b1;
    repeat (16) begin
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, 13'($urandom_range(0, 8191)),
                1'($urandom_range(0, 1)));
      send_item(1'b1, 8'($urandom_range(0, 255)), 1'b1, 13'($urandom_range(1, 7)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int phase_start;
    bit first_lookup;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 1; p <= 4; p++) begin
      settle();
      case (p)
        1: write_regs(1'b0, $urandom_range(2, 5000));
        2: write_regs(1'b1, 32'd2);
        3: write_regs(1'b0, 32'hFFFF_FFFF);
        default: write_regs(1'b1, $urandom | 32'h8000_0000);
      endcase
      if (p == 4) pressure_burst();
      phase_start  = items_sent;
      first_lookup = 1'b1;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        run_lookup(p == 2 && first_lookup);
        first_lookup = 1'b0;
        if ($urandom_range(0, 3) == 0) send_noise();
      end
    end
    settle();
    repeat (16) @(posedge clk);
    if (tracker.errors == 0 && tracker.due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/e2ds_pkg.sv
rtl/core/e2ds_ifs.sv
rtl/core/e2ds_name_store.sv
rtl/core/e2ds_parser.sv
rtl/core/ext2_directory_entry_scan_top.sv
verif/tb.sv
